// ===== rtl/core/gcf_pkg.sv =====
// gcf_pkg: shared constants and types for the glyph cache core
// used by glyph_cache_fifo_core and its port checker; no dependencies

package gcf_pkg;

   // default geometry
   localparam int SLOTS_DEF       = 16;
   localparam int GLYPH_BYTES_DEF = 32;

   // configuration register widths
   localparam int CFG_SLOTS_W = 5;
   localparam int CFG_LEN_W   = 6;
   localparam int CSR_DATA_W  = 6;

   // key and byte widths
   localparam int CODE_W = 8;
   localparam int KEY_W  = 2 * CODE_W;

   localparam logic [CODE_W-1:0] PAD_BYTE = 8'hFF;

   localparam logic [CFG_SLOTS_W-1:0] SLOTS_IN_USE_RST = 5'd0;
   localparam logic [CFG_LEN_W-1:0]   GLYPH_LEN_RST    = 6'd32;

   typedef enum logic [0:0] {
      CSR_SLOTS_IN_USE = 1'b0,
      CSR_GLYPH_LEN    = 1'b1
   } csr_idx_type;

   typedef enum logic [0:0] {
      CMD_LOOKUP = 1'b0,
      CMD_INSERT = 1'b1
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE    = 4'b0001,
      ST_KEY_RD  = 4'b0010,
      ST_KEY_CMP = 4'b0100,
      ST_STREAM  = 4'b1000
   } state_type;

endpackage

// ===== rtl/core/glyph_cache_fifo_core.sv =====
// glyph_cache_fifo_core: fully associative glyph cache with round-robin replacement
// depends on gcf_pkg; key, fill and glyph stores are local memories
//
//   channel | ports                                  | handshake
//   --------+----------------------------------------+----------------------------
//   request | req_command req_ku req_ten req_data_*  | start high while busy low
//   result  | rsp_hit rsp_glyph_byte rsp_last        | rsp_strobe, one cycle each
//   csr     | csr_index csr_wdata                    | csr_write_en, no wait
//
// an insert byte is written at acceptance and busy stays low
// a lookup walks the slots through one key comparator, with a key memory read state
// then a compare state for each slot; a hit then streams one byte a cycle out of the
// glyph memory read port
// reset clears valid bits, tail, insert count and the sequencer; no clearing pass
// results are shown for exactly one cycle each; the receiver cannot stall them

module glyph_cache_fifo_core #(
   parameter int SLOTS       = gcf_pkg::SLOTS_DEF,
   parameter int GLYPH_BYTES = gcf_pkg::GLYPH_BYTES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // request
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_command,
   input  logic [7:0]                          req_ku,
   input  logic [7:0]                          req_ten,
   input  logic [7:0]                          req_data_byte,
   input  logic                                req_data_last,
   // result
   output logic                                rsp_strobe,
   output logic                                rsp_hit,
   output logic [7:0]                          rsp_glyph_byte,
   output logic                                rsp_last,
   // configuration
   input  logic                                csr_write_en,
   input  gcf_pkg::csr_idx_type                csr_index,
   input  logic [gcf_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   import gcf_pkg::*;

   localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int BW = (GLYPH_BYTES > 1) ? $clog2(GLYPH_BYTES) : 1;
   localparam int CW = ($clog2(SLOTS + 1) > CFG_SLOTS_W) ? $clog2(SLOTS + 1) : CFG_SLOTS_W;
   localparam int LW = ($clog2(GLYPH_BYTES + 1) > CFG_LEN_W) ?
                       $clog2(GLYPH_BYTES + 1) : CFG_LEN_W;
   localparam int DEPTH = SLOTS << BW;

   // configuration registers
   logic [CFG_SLOTS_W-1:0] slots_in_use_ff;
   logic [CFG_LEN_W-1:0]   glyph_len_ff;

   // cache state
   logic [SLOTS-1:0]  valid_ff, valid_in;
   logic [SW-1:0]     tail_ff, tail_in;
   logic [LW-1:0]     cnt_ff, cnt_in;

   // sequencer
   state_type         state_ff, state_in;
   logic [CW-1:0]     idx_ff, idx_in;
   logic [LW-1:0]     byte_ff, byte_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic              rsp_strobe_ff, rsp_strobe_in;
   logic              rsp_hit_ff, rsp_hit_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              rsp_pad_ff, rsp_pad_in;

   // memories and their read registers
   logic [KEY_W-1:0]  key_mem  [SLOTS];
   logic [LW-1:0]     fill_mem [SLOTS];
   logic [7:0]        glyph_mem [DEPTH];
   logic [KEY_W-1:0]  key_q_ff;
   logic [LW-1:0]     fill_q_ff;
   logic [7:0]        glyph_q_ff;

   logic [CW-1:0]     eff_slots;
   logic [LW-1:0]     eff_len;
   logic [LW-1:0]     len_ext;
   logic [CW-1:0]     tail_plus;
   logic [LW-1:0]     cnt_plus;
   logic              accept;
   logic              do_insert;
   logic              glyph_we;
   logic              csr_slots_we;
   logic [SW+BW-1:0]  glyph_waddr;
   logic [SW+BW-1:0]  glyph_raddr;
   logic [SW-1:0]     rd_slot;

   assign busy        = (state_ff != ST_IDLE);
   assign accept      = start && !busy;
   assign csr_slots_we = csr_write_en && (csr_index == CSR_SLOTS_IN_USE);

   // effective slot count and slot length
   always_comb begin
      eff_slots = (CW'(slots_in_use_ff) > CW'(SLOTS)) ? CW'(SLOTS) : CW'(slots_in_use_ff);
      len_ext   = LW'(glyph_len_ff);
      if (len_ext == '0) begin
         eff_len = LW'(1);
      end else if (len_ext > LW'(GLYPH_BYTES)) begin
         eff_len = LW'(GLYPH_BYTES);
      end else begin
         eff_len = len_ext;
      end
   end

   // insert path, done at the accept edge
   assign do_insert   = accept && (req_command == CMD_INSERT) && (eff_slots != '0);
   assign glyph_we    = do_insert && (cnt_ff < eff_len);
   assign cnt_plus    = glyph_we ? (cnt_ff + LW'(1)) : cnt_ff;
   assign tail_plus   = CW'(tail_ff) + CW'(1);
   assign glyph_waddr = {tail_ff, cnt_ff[BW-1:0]};
   assign rd_slot     = idx_ff[SW-1:0];
   assign glyph_raddr = {rd_slot, byte_ff[BW-1:0]};

   always_comb begin
      valid_in = valid_ff;
      tail_in  = tail_ff;
      cnt_in   = cnt_ff;
      if (csr_slots_we) begin
         valid_in = '0;
         tail_in  = '0;
         cnt_in   = '0;
      end else if (do_insert) begin
         if (req_data_last) begin
            valid_in[tail_ff] = 1'b1;
            cnt_in            = '0;
            tail_in           = (tail_plus >= eff_slots) ? '0 : tail_plus[SW-1:0];
         end else begin
            cnt_in = cnt_plus;
            // first byte of a run takes the slot out of service
            if (cnt_ff == '0) begin
               valid_in[tail_ff] = 1'b0;
            end
         end
      end
   end

   // lookup sequencer
   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      byte_in       = byte_ff;
      key_in        = key_ff;
      rsp_strobe_in = 1'b0;
      rsp_hit_in    = rsp_hit_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_pad_in    = rsp_pad_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_command == CMD_LOOKUP)) begin
               key_in   = {req_ku, req_ten};
               idx_in   = '0;
               state_in = ST_KEY_RD;
            end
         end
         ST_KEY_RD: begin
            // all slots in use scanned: single miss transaction
            if (idx_ff >= eff_slots) begin
               rsp_strobe_in = 1'b1;
               rsp_hit_in    = 1'b0;
               rsp_last_in   = 1'b1;
               rsp_pad_in    = 1'b0;
               state_in      = ST_IDLE;
            end else begin
               state_in = ST_KEY_CMP;
            end
         end
         ST_KEY_CMP: begin
            if (valid_ff[rd_slot] && (key_q_ff == key_ff)) begin
               byte_in  = '0;
               state_in = ST_STREAM;
            end else begin
               idx_in   = idx_ff + CW'(1);
               state_in = ST_KEY_RD;
            end
         end
         ST_STREAM: begin
            // memory data for this byte lands in glyph_q_ff with the strobe
            rsp_strobe_in = 1'b1;
            rsp_hit_in    = 1'b1;
            rsp_pad_in    = (byte_ff >= fill_q_ff);
            rsp_last_in   = ((byte_ff + LW'(1)) == eff_len);
            if (rsp_last_in) begin
               state_in = ST_IDLE;
            end else begin
               byte_in = byte_ff + LW'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slots_in_use_ff <= SLOTS_IN_USE_RST;
         glyph_len_ff    <= GLYPH_LEN_RST;
         valid_ff        <= '0;
         tail_ff         <= '0;
         cnt_ff          <= '0;
         state_ff        <= ST_IDLE;
         rsp_strobe_ff   <= 1'b0;
      end else begin
         if (csr_write_en) begin
            unique case (csr_index)
               CSR_SLOTS_IN_USE: slots_in_use_ff <= csr_wdata[CFG_SLOTS_W-1:0];
               CSR_GLYPH_LEN:    glyph_len_ff    <= csr_wdata[CFG_LEN_W-1:0];
            endcase
         end
         valid_ff      <= valid_in;
         tail_ff       <= tail_in;
         cnt_ff        <= cnt_in;
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      byte_ff     <= byte_in;
      key_ff      <= key_in;
      rsp_hit_ff  <= rsp_hit_in;
      rsp_last_ff <= rsp_last_in;
      rsp_pad_ff  <= rsp_pad_in;
   end

   // key and fill-count memories: written by inserts, read during the scan
   always_ff @(posedge clock) begin
      if (do_insert) begin
         key_mem[tail_ff] <= {req_ku, req_ten};
      end
      if (do_insert && req_data_last) begin
         fill_mem[tail_ff] <= cnt_plus;
      end
      if (state_ff == ST_KEY_RD) begin
         key_q_ff  <= key_mem[rd_slot];
         fill_q_ff <= fill_mem[rd_slot];
      end
   end

   // glyph byte memory
   always_ff @(posedge clock) begin
      if (glyph_we) begin
         glyph_mem[glyph_waddr] <= req_data_byte;
      end
      glyph_q_ff <= glyph_mem[glyph_raddr];
   end

   // bytes at or past the slot's fill count read as padding
   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_last       = rsp_last_ff;
   assign rsp_glyph_byte = !rsp_hit_ff ? 8'h00 : (rsp_pad_ff ? PAD_BYTE : glyph_q_ff);

endmodule

// ===== rtl/core/gcf_checker.sv =====
// gcf_checker: port-level checks on the glyph cache core result stream
// depends on gcf_pkg; bound to glyph_cache_fifo_core at the end of this file

module gcf_checker (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       req_command,
   input logic       rsp_strobe,
   input logic       rsp_hit,
   input logic [7:0] rsp_glyph_byte,
   input logic       rsp_last
);

   import gcf_pkg::*;

   // a miss is always a single closing transaction with a zero byte
   miss_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_hit) |-> (rsp_last && (rsp_glyph_byte == 8'h00)))
      else $error("miss result not closing or nonzero");

   // a hit stream has no gaps until its last byte
   stream_gapless: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_last) |=> (rsp_strobe && rsp_hit))
      else $error("hit stream broken before last byte");

   // an accepted lookup makes the core busy
   lookup_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_command == CMD_LOOKUP)) |=> busy)
      else $error("lookup accepted without going busy");

   // no result without a lookup in flight
   strobe_needs_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result strobe with no lookup in flight");

   // reset leaves the result channel quiet
   reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_strobe)
      else $error("result strobe right after reset");

endmodule

bind glyph_cache_fifo_core gcf_checker u_gcf_checker (.*);

// ===== verif/tb_glyph_cache_fifo_core.sv =====
// tb_glyph_cache_fifo_core: self-checking bench for the glyph cache core, directed then random
// depends on gcf_pkg and glyph_cache_fifo_core; a local cache predictor checks every result byte

module tb_glyph_cache_fifo_core;
   import gcf_pkg::*;

   localparam int NSLOT       = SLOTS_DEF;
   localparam int NBYTE       = GLYPH_BYTES_DEF;
   localparam int SETTLE      = 2 * NSLOT + NBYTE + 8;
   localparam int CYCLE_LIMIT = 300000;
   localparam int RAND_ITEMS  = 370;
   localparam int MAX_REPORTS = 10;

   typedef struct {
      cmd_type     command;
      logic [7:0]  ku;
      logic [7:0]  ten;
      logic [7:0]  data_byte;
      logic        data_last;
   } glyph_req_type;

   typedef struct {
      logic        hit;
      logic [7:0]  glyph_byte;
      logic        last;
   } glyph_rsp_type;

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   logic                   req_command;
   logic [7:0]             req_ku;
   logic [7:0]             req_ten;
   logic [7:0]             req_data_byte;
   logic                   req_data_last;
   logic                   rsp_strobe;
   logic                   rsp_hit;
   logic [7:0]             rsp_glyph_byte;
   logic                   rsp_last;
   logic                   csr_write_en;
   csr_idx_type            csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   glyph_cache_fifo_core u_top (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_command    (req_command),
      .req_ku         (req_ku),
      .req_ten        (req_ten),
      .req_data_byte  (req_data_byte),
      .req_data_last  (req_data_last),
      .rsp_strobe     (rsp_strobe),
      .rsp_hit        (rsp_hit),
      .rsp_glyph_byte (rsp_glyph_byte),
      .rsp_last       (rsp_last),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // predicted cache contents
   logic [CFG_SLOTS_W-1:0] cache_slots;
   logic [CFG_LEN_W-1:0]   cache_len;
   logic [KEY_W-1:0]       cache_key   [NSLOT];
   logic                   cache_valid [NSLOT];
   logic [7:0]             cache_glyph [NSLOT][NBYTE];
   logic [3:0]             pred_tail;
   logic [5:0]             cache_fill;

   glyph_req_type    pending_req_q[$];
   glyph_rsp_type    glyph_expect_q[$];
   logic [KEY_W-1:0] recent_keys[$];
   glyph_req_type    cur_req;

   int  queued_count;
   int  taken_count;
   int  lookup_count;
   int  hit_bytes;
   int  miss_count;
   int  mismatch_count;
   int  csr_writes;
   int  cycle_count;
   bit  no_idle;

   function automatic int live_slots();
      return (int'(cache_slots) > NSLOT) ? NSLOT : int'(cache_slots);
   endfunction

   function automatic int live_len();
      if (cache_len < 1) return 1;
      if (int'(cache_len) > NBYTE) return NBYTE;
      return int'(cache_len);
   endfunction

   task automatic clear_valid();
      for (int s = 0; s < NSLOT; s++) cache_valid[s] = 1'b0;
      pred_tail  = '0;
      cache_fill = '0;
   endtask

   // apply one accepted transaction to the cache image, queue the bytes it should return
   task automatic cache_predict(input glyph_req_type it);
      int               ns;
      int               len;
      int               s;
      int               found;
      logic [KEY_W-1:0] key;
      glyph_rsp_type    r;
      ns  = live_slots();
      len = live_len();
      key = {it.ku, it.ten};
      if (it.command == CMD_INSERT) begin
         if (ns != 0) begin
            s = int'(pred_tail) % NSLOT;
            if (cache_fill == 0) cache_valid[s] = 1'b0;
            cache_key[s] = key;
            if (int'(cache_fill) < len) begin
               cache_glyph[s][cache_fill] = it.data_byte;
               cache_fill = cache_fill + 1'b1;
            end
            if (it.data_last) begin
               for (int i = int'(cache_fill); i < NBYTE; i++) cache_glyph[s][i] = PAD_BYTE;
               cache_valid[s] = 1'b1;
               cache_fill = '0;
               pred_tail = (s + 1 >= ns) ? 4'd0 : 4'(s + 1);
            end
         end
      end else begin
         found = -1;
         for (s = 0; s < ns; s++) begin
            if (found < 0 && cache_valid[s] && cache_key[s] == key) found = s;
         end
         if (found >= 0) begin
            for (int i = 0; i < len; i++) begin
               r.hit        = 1'b1;
               r.glyph_byte = cache_glyph[found][i];
               r.last       = (i + 1 == len);
               glyph_expect_q.push_back(r);
            end
         end else begin
            r.hit        = 1'b0;
            r.glyph_byte = 8'h00;
            r.last       = 1'b1;
            glyph_expect_q.push_back(r);
         end
      end
   endtask

   task automatic push_req(input cmd_type cmd, input logic [KEY_W-1:0] key,
                           input logic [7:0] data, input logic last);
      glyph_req_type it;
      it.command   = cmd;
      it.ku        = key[15:8];
      it.ten       = key[7:0];
      it.data_byte = data;
      it.data_last = last;
      pending_req_q.push_back(it);
      queued_count++;
   endtask

   task automatic note_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) $display("mismatch at cycle %0d: %s", cycle_count, msg);
   endtask

   // register writes only happen with the core idle, so the predictor updates right here
   task automatic write_csr(input csr_idx_type idx, input logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= val;
      @(posedge clock);
      csr_write_en <= 1'b0;
      if (idx == CSR_SLOTS_IN_USE) begin
         cache_slots = val[CFG_SLOTS_W-1:0];
         clear_valid();
      end else begin
         cache_len = val[CFG_LEN_W-1:0];
      end
      csr_writes++;
   endtask

   task automatic wait_drained();
      while (taken_count != queued_count || glyph_expect_q.size() != 0 || busy)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic pick_key(output logic [KEY_W-1:0] key, input int reuse_pct);
      if (recent_keys.size() != 0 && $urandom_range(99) < reuse_pct)
         key = recent_keys[$urandom_range(recent_keys.size() - 1)];
      else
         key = 16'($urandom);
   endtask

   // mostly whole insert runs and lookups of recent keys, some stray bytes
   task automatic gen_phase(input int target, output int made);
      int               r;
      int               n;
      int               lenv;
      logic [KEY_W-1:0] key;
      logic [KEY_W-1:0] kb;
      made   = 0;
      lenv   = live_len();
      while (made < target) begin
         r = $urandom_range(99);
         if (r < 45) begin
            pick_key(key, 25);
            if ($urandom_range(9) == 0) n = $urandom_range(1, NBYTE + 4);
            else n = $urandom_range(1, lenv + 2);
            for (int k = 0; k < n; k++) begin
               kb = key;
               if (k != n - 1 && $urandom_range(19) == 0) kb = 16'($urandom);
               push_req(CMD_INSERT, kb, 8'($urandom),
                        (k == n - 1) && ($urandom_range(9) != 0));
               made++;
            end
            recent_keys.push_back(key);
            if (recent_keys.size() > 10) void'(recent_keys.pop_front());
         end else if (r < 85) begin
            pick_key(key, 75);
            push_req(CMD_LOOKUP, key, 8'($urandom), 1'($urandom));
            made++;
         end else begin
            push_req(CMD_INSERT, 16'($urandom), 8'($urandom), 1'($urandom));
            made++;
         end
      end
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, glyph_expect_q.size());
         $display("FAILURE");
         $finish;
      end
   end

   // driver: one transaction per start/busy handshake
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!(start && busy)) begin
         if (start) begin
            cache_predict(cur_req);
            taken_count++;
            if (cur_req.command == CMD_LOOKUP) lookup_count++;
         end
         if (pending_req_q.size() != 0 && (no_idle || $urandom_range(99) >= 36)) begin
            cur_req = pending_req_q.pop_front();
            req_command   <= cur_req.command;
            req_ku        <= cur_req.ku;
            req_ten       <= cur_req.ten;
            req_data_byte <= cur_req.data_byte;
            req_data_last <= cur_req.data_last;
            start         <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: every strobe is compared against the oldest predicted byte
   always @(posedge clock) begin : rsp_monitor
      glyph_rsp_type want;
      if (!reset && rsp_strobe) begin
         if (glyph_expect_q.size() == 0) begin
            note_mismatch($sformatf("unexpected result hit=%0d byte=%02h last=%0d",
                                    rsp_hit, rsp_glyph_byte, rsp_last));
         end else begin
            want = glyph_expect_q.pop_front();
            if (want.hit) hit_bytes++;
            else miss_count++;
            if (rsp_hit !== want.hit || rsp_glyph_byte !== want.glyph_byte ||
                rsp_last !== want.last)
               note_mismatch($sformatf("exp hit=%0d byte=%02h last=%0d, got hit=%0d byte=%02h last=%0d",
                                       want.hit, want.glyph_byte, want.last,
                                       rsp_hit, rsp_glyph_byte, rsp_last));
         end
      end
   end

   initial begin
      int made;
      int random_items;
      int ph;
      int r;
      logic [CFG_SLOTS_W-1:0] nslots;
      logic [CFG_LEN_W-1:0]   nlen;

      reset         = 1'b1;
      start         = 1'b0;
      req_command   = CMD_LOOKUP;
      req_ku        = '0;
      req_ten       = '0;
      req_data_byte = '0;
      req_data_last = 1'b0;
      csr_write_en  = 1'b0;
      csr_index     = CSR_SLOTS_IN_USE;
      csr_wdata     = '0;
      cycle_count   = 0;
      queued_count  = 0;
      taken_count   = 0;
      lookup_count  = 0;
      hit_bytes     = 0;
      miss_count    = 0;
      mismatch_count = 0;
      csr_writes    = 0;
      no_idle       = 1'b0;
      cache_slots   = SLOTS_IN_USE_RST;
      cache_len     = GLYPH_LEN_RST;
      for (int s = 0; s < NSLOT; s++) begin
         cache_key[s] = '0;
         for (int i = 0; i < NBYTE; i++) cache_glyph[s][i] = '0;
      end
      clear_valid();

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // disabled after reset: lookups miss, inserts are dropped
      push_req(CMD_LOOKUP, 16'h0000, 8'h00, 1'b0);
      push_req(CMD_INSERT, 16'hFFFF, 8'h5A, 1'b1);
      push_req(CMD_LOOKUP, 16'hFFFF, 8'hFF, 1'b1);
      wait_drained();

      write_csr(CSR_SLOTS_IN_USE, 6'd16);
      write_csr(CSR_GLYPH_LEN, 6'd32);
      // short insert padded out, hit and miss
      push_req(CMD_INSERT, 16'hFFFF, 8'hFF, 1'b0);
      push_req(CMD_INSERT, 16'hFFFF, 8'h00, 1'b0);
      push_req(CMD_INSERT, 16'hFFFF, 8'hA5, 1'b1);
      push_req(CMD_LOOKUP, 16'hFFFF, 8'h00, 1'b0);
      push_req(CMD_LOOKUP, 16'h0000, 8'h00, 1'b0);
      // key of the final byte wins
      push_req(CMD_INSERT, 16'h1234, 8'h81, 1'b0);
      push_req(CMD_INSERT, 16'h0000, 8'h7E, 1'b1);
      push_req(CMD_LOOKUP, 16'h1234, 8'h00, 1'b0);
      push_req(CMD_LOOKUP, 16'h0000, 8'h00, 1'b0);
      // slot under fill cannot match
      push_req(CMD_INSERT, 16'h5A5A, 8'h3C, 1'b0);
      push_req(CMD_LOOKUP, 16'h5A5A, 8'h00, 1'b0);
      push_req(CMD_INSERT, 16'h5A5A, 8'hC3, 1'b1);
      push_req(CMD_LOOKUP, 16'h5A5A, 8'h00, 1'b0);
      // duplicate key, lowest slot answers
      push_req(CMD_INSERT, 16'hFFFF, 8'h11, 1'b1);
      push_req(CMD_LOOKUP, 16'hFFFF, 8'h00, 1'b0);
      wait_drained();

      // single one-byte slot, excess bytes dropped, tail wraps
      write_csr(CSR_SLOTS_IN_USE, 6'd1);
      write_csr(CSR_GLYPH_LEN, 6'd1);
      push_req(CMD_INSERT, 16'hABCD, 8'h01, 1'b0);
      push_req(CMD_INSERT, 16'hABCD, 8'h02, 1'b0);
      push_req(CMD_INSERT, 16'hABCD, 8'h03, 1'b1);
      push_req(CMD_LOOKUP, 16'hABCD, 8'h00, 1'b0);
      push_req(CMD_INSERT, 16'h7E81, 8'h99, 1'b0);
      wait_drained();

      // length grows while an insert is open
      write_csr(CSR_GLYPH_LEN, 6'd4);
      push_req(CMD_INSERT, 16'h7E81, 8'h42, 1'b1);
      push_req(CMD_LOOKUP, 16'h7E81, 8'h00, 1'b0);
      wait_drained();

      random_items = 0;
      ph = 0;
      while (random_items < RAND_ITEMS) begin
         r = $urandom_range(9);
         case (r)
            0: nslots = 5'd0;
            1: nslots = 5'd1;
            2: nslots = 5'd16;
            3: nslots = 5'd2;
            default: nslots = 5'($urandom_range(1, 16));
         endcase
         r = $urandom_range(9);
         if (r == 0) nlen = 6'd1;
         else if (r == 1) nlen = 6'd32;
         else if (r < 7) nlen = 6'($urandom_range(1, 8));
         else nlen = 6'($urandom_range(1, 32));
         // now and then keep the slot count so an open insert survives a length change
         if (ph == 0 || $urandom_range(99) < 65) write_csr(CSR_SLOTS_IN_USE, {1'b0, nslots});
         write_csr(CSR_GLYPH_LEN, nlen);
         no_idle = (ph == 3);
         gen_phase($urandom_range(25, 45), made);
         random_items += made;
         wait_drained();
         ph++;
      end
      no_idle = 1'b0;

      $display("covered %0d transactions (%0d lookups) across %0d register writes",
               taken_count, lookup_count, csr_writes);
      $display("checked %0d hit bytes and %0d misses, %0d mismatches",
               hit_bytes, miss_count, mismatch_count);
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/gcf_pkg.sv
rtl/core/glyph_cache_fifo_core.sv
rtl/core/gcf_checker.sv
verif/tb_glyph_cache_fifo_core.sv
